// ----- design/bbpf_pkg.sv -----
`timescale 1ns / 1ps

package bbpf_pkg;

	localparam int SLOTS    = 1024;
	localparam int PTR_W    = $clog2(SLOTS);
	localparam int OCC_W    = $clog2(SLOTS + 1);
	localparam int HANDLE_W = 16;
	localparam int LEN_W    = 16;
	localparam int WORD_W   = HANDLE_W + LEN_W;
	localparam int BYTES_W  = 24;
	localparam int ENTRY_W  = 11;

	localparam logic [BYTES_W-1:0] CAP_RESET = 24'd65536;

	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [OCC_W-1:0]    occ_t;
	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [BYTES_W-1:0]  bytes_t;
	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [LEN_W-1:0]    len_t;

	typedef enum logic {
		FN_PUSH = 1'b0,
		FN_POP  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BUDGET = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic    we;
		ptr_t    waddr;
		word_t   wdata;
		logic    re;
		ptr_t    raddr;
	} ram_req_t;

	function automatic ptr_t next_ptr(input ptr_t p);
		return (p == PTR_W'(SLOTS - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

endpackage

// ----- design/bbpf_slot_store.sv -----
`timescale 1ns / 1ps

module bbpf_slot_store (
	input  logic               clk,
	input  logic               arst_n,
	input  bbpf_pkg::ram_req_t req,
	output bbpf_pkg::word_t    rdata
);
	import bbpf_pkg::*;

	word_t mem [SLOTS];
	word_t mem_q;
	word_t fwd_data_q;
	logic  fwd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			mem_q      <= mem[req.raddr];
			fwd_data_q <= req.wdata;
		end
	end

	// bypass a read that hits the entry written at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (req.re) begin
			fwd_q <= req.we && (req.waddr == req.raddr);
		end
	end

	assign rdata = fwd_q ? fwd_data_q : mem_q;

endmodule

// ----- design/byte_budget_packet_fifo_core.sv -----
`timescale 1ns / 1ps

// Packet descriptor queue with a byte budget.
// Input channel: in_valid/in_stall carry one item (func, handle, pkt_length).
// A push is taken if bytes in use plus pkt_length stay below byte_capacity and
// a slot is free; a pop returns the oldest handle and length.
// Output channel: out_valid/out_stall carry one result item per input item:
// accepted, status, out_handle, out_length, entry_count, bytes_in_use.
// An accepted item enters the work stage as the slot memory read starts; its
// result is loaded into the output register when the work stage advances.
// Throughput: one item per cycle while out_stall is low; a pop's slot memory
// read overlaps the completion of the item ahead, with read-after-write bypass.
// byte_capacity is written through cfg_wr_en/cfg_wr_data, by the user only while
// the block is idle (not enforced by the block); it resets to 65536.
// Reset empties the queue, clears both counts and pointers; slot contents are
// not cleared and need no clearing pass.
// When the receiver holds out_stall, the result holds, one more item may enter
// and wait in the work stage, and in_stall rises after that.

module byte_budget_packet_fifo_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  bbpf_pkg::bytes_t          cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  bbpf_pkg::handle_t         handle,
	input  bbpf_pkg::len_t            pkt_length,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      accepted,
	output logic [1:0]                status,
	output bbpf_pkg::handle_t         out_handle,
	output bbpf_pkg::len_t            out_length,
	output logic [bbpf_pkg::ENTRY_W-1:0] entry_count,
	output bbpf_pkg::bytes_t          bytes_in_use
);
	import bbpf_pkg::*;

	bytes_t  cap_q;
	ptr_t    wr_ptr_q;
	ptr_t    rd_ptr_q;
	occ_t    occ_q;
	bytes_t  bytes_q;

	logic    valid_s1;
	func_t   func_s1;
	handle_t handle_s1;
	len_t    len_s1;

	logic    out_valid_q;
	logic    acc_q;
	status_t status_q;
	handle_t out_handle_q;
	len_t    out_length_q;
	occ_t    out_occ_q;
	bytes_t  out_bytes_q;

	ram_req_t ram_req;
	word_t    rdata;

	logic               in_take;
	logic               s1_adv;
	logic [BYTES_W:0]   sum;
	logic               push_ok;
	logic               pop_ok;
	status_t            status_d;
	len_t               pop_len;
	occ_t               occ_d;
	bytes_t             bytes_d;

	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_take  = in_valid && !in_stall;

	assign pop_len = rdata[LEN_W-1:0];
	assign sum     = (BYTES_W + 1)'(bytes_q) + (BYTES_W + 1)'(len_s1);

	always_comb begin
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		status_d = ST_OK;
		occ_d    = occ_q;
		bytes_d  = bytes_q;
		case (func_s1)
			FN_PUSH: begin
				if (sum >= (BYTES_W + 1)'(cap_q)) begin
					status_d = ST_BUDGET;
				end else if (occ_q >= OCC_W'(SLOTS)) begin
					status_d = ST_FULL;
				end else begin
					push_ok = 1'b1;
					occ_d   = occ_q + 1'b1;
					bytes_d = sum[BYTES_W-1:0];
				end
			end
			FN_POP: begin
				if (occ_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					pop_ok  = 1'b1;
					occ_d   = occ_q - 1'b1;
					bytes_d = (bytes_q >= BYTES_W'(pop_len)) ?
						bytes_t'(bytes_q - BYTES_W'(pop_len)) : '0;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_comb begin
		ram_req.we    = s1_adv && push_ok;
		ram_req.waddr = wr_ptr_q;
		ram_req.wdata = {handle_s1, len_s1};
		ram_req.re    = in_take;
		ram_req.raddr = (s1_adv && pop_ok) ? next_ptr(rd_ptr_q) : rd_ptr_q;
	end

	bbpf_slot_store u_slot_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			bytes_q  <= '0;
		end else if (s1_adv) begin
			occ_q   <= occ_d;
			bytes_q <= bytes_d;
			if (push_ok) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop_ok) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1   <= func_t'(func);
			handle_s1 <= handle;
			len_s1    <= pkt_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			acc_q        <= push_ok || pop_ok;
			status_q     <= status_d;
			out_handle_q <= pop_ok ? rdata[WORD_W-1:LEN_W] : '0;
			out_length_q <= pop_ok ? pop_len : '0;
			out_occ_q    <= occ_d;
			out_bytes_q  <= bytes_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = acc_q;
	assign status       = status_q;
	assign out_handle   = out_handle_q;
	assign out_length   = out_length_q;
	assign entry_count  = ENTRY_W'(out_occ_q);
	assign bytes_in_use = out_bytes_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(SLOTS))
		else $error("occupancy above slot count");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && push_ok |=> occ_q == $past(occ_q) + 1'b1)
		else $error("push did not advance occupancy");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && pop_ok |=> occ_q == $past(occ_q) - 1'b1)
		else $error("pop did not reduce occupancy");

	a_status_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (acc_q == (status_q == ST_OK)))
		else $error("accepted flag disagrees with status");

	a_empty_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> bytes_q == '0)
		else $error("bytes in use with empty queue");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import bbpf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic                 acc;
		status_t              st;
		handle_t              oh;
		len_t                 ol;
		logic [ENTRY_W-1:0]   cnt;
		bytes_t               bytes;
	} fifo_result_t;

	class fifo_tracker;
		word_t        held[$];
		int unsigned  byte_total;
		int unsigned  capacity;
		int unsigned  full_refusals;
		int unsigned  errors;
		fifo_result_t pending_results[$];

		function new();
			byte_total = 0;
			capacity = CAP_RESET;
			full_refusals = 0;
			errors = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void apply_item(func_t f, handle_t h, len_t l);
			fifo_result_t r;
			word_t w;
			r = '0;
			r.st = ST_OK;
			if (f == FN_PUSH) begin
				if (byte_total + l >= capacity) begin
					r.st = ST_BUDGET;
				end else if (held.size() >= SLOTS) begin
					r.st = ST_FULL;
					full_refusals++;
				end else begin
					held.push_back({h, l});
					byte_total = (byte_total + l) & 32'hFF_FFFF;
					r.acc = 1'b1;
				end
			end else if (held.size() == 0) begin
				r.st = ST_EMPTY;
			end else begin
				w = held.pop_front();
				r.oh = w[WORD_W-1:LEN_W];
				r.ol = w[LEN_W-1:0];
				byte_total = (byte_total >= r.ol) ? byte_total - r.ol : 0;
				r.acc = 1'b1;
			end
			r.cnt = ENTRY_W'(held.size());
			r.bytes = bytes_t'(byte_total);
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic acc, logic [1:0] st, handle_t oh, len_t ol,
				logic [ENTRY_W-1:0] cnt, bytes_t bytes);
			fifo_result_t e;
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
				return;
			end
			e = pending_results.pop_front();
			compare_field("accepted", 32'(e.acc), 32'(acc));
			compare_field("status", 32'(e.st), 32'(st));
			compare_field("out_handle", 32'(e.oh), 32'(oh));
			compare_field("out_length", 32'(e.ol), 32'(ol));
			compare_field("entry_count", 32'(e.cnt), 32'(cnt));
			compare_field("bytes_in_use", 32'(e.bytes), 32'(bytes));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	bytes_t              cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	logic                func;
	handle_t             handle;
	len_t                pkt_length;
	logic                out_valid;
	logic                out_stall;
	logic                accepted;
	logic [1:0]          status;
	handle_t             out_handle;
	len_t                out_length;
	logic [ENTRY_W-1:0]  entry_count;
	bytes_t              bytes_in_use;

	fifo_tracker  book;
	int unsigned  burst_left = 0;
	int unsigned  cycle_count = 0;
	int unsigned  stall_mode = 0;
	int unsigned  stall_left = 0;

	byte_budget_packet_fifo_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.handle       (handle),
		.pkt_length   (pkt_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.status       (status),
		.out_handle   (out_handle),
		.out_length   (out_length),
		.entry_count  (entry_count),
		.bytes_in_use (bytes_in_use)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("byte_budget_packet_fifo_core: mismatch");
			$finish;
		end
	end

	// check results, then pick the next stall level
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_result(accepted, status, out_handle, out_length, entry_count,
				bytes_in_use);
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 160);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((cycle_count % 12) < 7);
		endcase
	end

	task automatic send_item(func_t f, handle_t h, len_t l);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		func <= f;
		handle <= h;
		pkt_length <= l;
		do @(posedge clk); while (in_stall);
		book.apply_item(f, h, l);
		burst_left--;
	endtask

	task automatic random_item(int unsigned push_pct, bit wide);
		len_t l;
		func_t f;
		if (wide || $urandom_range(0, 7) == 0)
			l = len_t'($urandom);
		else if ($urandom_range(0, 5) == 0)
			l = '0;
		else
			l = len_t'($urandom_range(1, 255));
		f = ($urandom_range(0, 99) < push_pct) ? FN_PUSH : FN_POP;
		send_item(f, handle_t'($urandom), l);
	endtask

	// drain everything in flight before touching the register
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (book.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(bytes_t v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		book.capacity = v;
	endtask

	initial begin
		int unsigned guard;
		book = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		func = FN_PUSH;
		handle = '0;
		pkt_length = '0;
		out_stall = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// budget at reset value
		send_item(FN_POP, 16'h0000, 16'h0000);
		send_item(FN_PUSH, 16'h0000, 16'h0000);
		send_item(FN_PUSH, 16'hFFFF, 16'hFFFF);
		send_item(FN_PUSH, 16'h1234, 16'h0001);
		send_item(FN_PUSH, 16'hBEEF, 16'h0000);
		send_item(FN_POP, 16'hFFFF, 16'hFFFF);
		send_item(FN_POP, 16'h0000, 16'h0000);
		send_item(FN_POP, 16'h0000, 16'h0000);
		send_item(FN_POP, 16'h0000, 16'h0000);
		send_item(FN_PUSH, 16'hA5A5, 16'h5A5A);
		send_item(FN_PUSH, 16'h5A5A, 16'hA5A5);
		send_item(FN_POP, 16'h0000, 16'h0000);
		send_item(FN_POP, 16'h0000, 16'h0000);

		// zero budget refuses even empty packets
		write_capacity('0);
		send_item(FN_PUSH, 16'h0000, 16'h0000);
		send_item(FN_PUSH, 16'h0007, 16'h0000);
		repeat (20) random_item(70, 0);

		// fill to the slot limit
		write_capacity(24'hFF_FFFF);
		guard = 0;
		while (book.full_refusals < 4 && guard < 1500) begin
			random_item(100, 0);
			guard++;
		end

		// drop the budget under bytes in use while full
		write_capacity(24'd1);
		repeat (6) random_item(100, 0);
		repeat (20) random_item(12, 0);

		write_capacity(bytes_t'($urandom_range(2, 300000)));
		repeat (20) random_item(50, 1);

		settle();
		repeat (8) @(posedge clk);
		if (book.errors == 0)
			$display("byte_budget_packet_fifo_core: match");
		else
			$display("byte_budget_packet_fifo_core: mismatch");
		$finish;
	end

endmodule
